// ===== rtl/ffca_pkg.sv =====
// ----------------------------------------------------------------------------
// ffca_pkg
// Shared types and constants for the first-fit coalescing heap allocator.
// ----------------------------------------------------------------------------
package ffca_pkg;

  localparam int HEAP_BYTES   = 65536;
  localparam int HEADER_BYTES = 16;
  localparam int ALIGN_BYTES  = 8;

  localparam int HDR      = (HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES * ALIGN_BYTES;
  localparam int GRANULES = HEAP_BYTES / ALIGN_BYTES;
  localparam int END_BYTE = (HEAP_BYTES - HDR) / ALIGN_BYTES * ALIGN_BYTES;
  localparam int END_G    = END_BYTE / ALIGN_BYTES;
  localparam int ALIGN_SH = $clog2(ALIGN_BYTES);

  localparam int GW      = $clog2(GRANULES);      // granule index
  localparam int SW      = 17;                    // block size / byte count
  localparam int AW      = SW + 1;                // byte sums
  localparam int GUARD_W = $clog2(GRANULES + 2);

  localparam logic [GW-1:0]      END_GRAN  = GW'(END_G);
  localparam logic [SW-1:0]      END_SIZE  = SW'(END_BYTE);
  localparam logic [SW-1:0]      HEAP_SIZE = SW'(HEAP_BYTES);
  localparam logic [GUARD_W-1:0] GUARD_MAX = GUARD_W'(GRANULES);

  // result status codes
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_NULL    = 2'd1;
  localparam logic [1:0] ST_IGNORED = 2'd2;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [16:0] alloc_size;
    logic [15:0] free_address;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] block_address;
    logic [16:0] free_bytes;
    logic [16:0] taken_bytes;
  } rsp_t;

  typedef enum logic [16:0] {
    S_CLEAR    = 17'h00001,
    S_IDLE     = 17'h00002,
    S_DECODE   = 17'h00004,
    S_WALK_RD  = 17'h00008,
    S_WALK_EV  = 17'h00010,
    S_TAKE     = 17'h00020,
    S_SPLIT    = 17'h00040,
    S_FREE_CHK = 17'h00080,
    S_PB_START = 17'h00100,
    S_PB_CHK   = 17'h00200,
    S_PB_NEXT  = 17'h00400,
    S_PB_RDG   = 17'h00800,
    S_PB_PREV  = 17'h01000,
    S_PB_NXCHK = 17'h02000,
    S_PB_ABSRB = 17'h04000,
    S_PB_LINK  = 17'h08000,
    S_DONE     = 17'h10000
  } state_t;

  typedef struct packed {
    state_t     step;
    logic       res_we;
    logic [1:0] res;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_alloc;
    logic alloc_ok;
    logic addr_ok;
    logic at_end;
    logic fits;
    logic guard_ok;
    logic mark_set;
    logic do_split;
    logic pb_go;
    logic nxt_adj;
    logic nxt_end;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== rtl/ffca_ctrl.sv =====
// ----------------------------------------------------------------------------
// ffca_ctrl
// Sequencer for clearing, list walk, split and put-back with coalescing.
// ----------------------------------------------------------------------------
module ffca_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  ffca_pkg::dp_stat_t st,
  output ffca_pkg::cmd_t    cmd,
  output logic              in_stall
);
  import ffca_pkg::*;

  state_t     state, state_next;
  logic       res_we;
  logic [1:0] res;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    res_we     = 1'b0;
    res        = ST_DONE;
    unique case (state)
      S_CLEAR: begin
        if (st.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        if (st.is_alloc) begin
          if (st.alloc_ok) begin
            state_next = S_WALK_RD;
          end else begin
            res_we = 1'b1; res = ST_NULL; state_next = S_DONE;
          end
        end else if (st.addr_ok) begin
          state_next = S_FREE_CHK;
        end else begin
          res_we = 1'b1; res = ST_IGNORED; state_next = S_DONE;
        end
      end
      S_WALK_RD: begin
        if (st.at_end) begin
          res_we = 1'b1; res = ST_NULL; state_next = S_DONE;
        end else begin
          state_next = S_WALK_EV;
        end
      end
      S_WALK_EV: begin
        if (!st.fits && st.guard_ok) begin
          state_next = S_WALK_RD;
        end else if (st.fits) begin
          state_next = S_TAKE;
        end else begin
          res_we = 1'b1; res = ST_NULL; state_next = S_DONE;
        end
      end
      S_TAKE: begin
        if (st.do_split) begin
          state_next = S_SPLIT;
        end else begin
          res_we = 1'b1; res = ST_DONE; state_next = S_DONE;
        end
      end
      S_SPLIT:    state_next = S_PB_START;
      S_FREE_CHK: begin
        if (st.mark_set) begin
          state_next = S_PB_START;
        end else begin
          res_we = 1'b1; res = ST_IGNORED; state_next = S_DONE;
        end
      end
      S_PB_START: state_next = S_PB_CHK;
      S_PB_CHK:   state_next = st.pb_go ? S_PB_NEXT : S_PB_RDG;
      S_PB_NEXT:  state_next = S_PB_CHK;
      S_PB_RDG:   state_next = S_PB_PREV;
      S_PB_PREV:  state_next = S_PB_NXCHK;
      S_PB_NXCHK: state_next = (st.nxt_adj && !st.nxt_end) ? S_PB_ABSRB : S_PB_LINK;
      S_PB_ABSRB: state_next = S_PB_LINK;
      S_PB_LINK: begin
        res_we = 1'b1; res = ST_DONE; state_next = S_DONE;
      end
      S_DONE: begin
        if (st.out_free) state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  assign cmd.step   = state;
  assign cmd.res_we = res_we;
  assign cmd.res    = res;
  assign in_stall   = (state != S_IDLE);

endmodule

// ===== rtl/ffca_dp.sv =====
// ----------------------------------------------------------------------------
// ffca_dp
// Heap header memories, walk registers, byte counter and result register.
// ----------------------------------------------------------------------------
module ffca_dp (
  input  logic               clk,
  input  logic               rst,
  input  ffca_pkg::cmd_t     cmd,
  input  logic               in_valid,
  input  ffca_pkg::req_t     in_data,
  input  logic               out_stall,
  output logic               out_valid,
  output ffca_pkg::rsp_t     out_data,
  output ffca_pkg::dp_stat_t st
);
  import ffca_pkg::*;

  logic [SW-1:0] size_mem [GRANULES];
  logic [GW-1:0] link_mem [GRANULES];
  logic          mark_mem [GRANULES];

  logic [SW-1:0] rd_size;
  logic [GW-1:0] rd_link;
  logic          rd_mark;

  req_t               req;
  logic [GW-1:0]      clr, head, blk, prv, g, it, lnk, link_blk;
  logic               prev_none, it_none;
  logic [GUARD_W-1:0] guard;
  logic [SW-1:0]      free_cnt, sz_blk, sz_g, sz_it;
  logic [1:0]         res_status;
  logic [15:0]        res_addr;

  logic [GW-1:0] rd_addr;
  logic          size_we, link_we, mark_we, mark_wd;
  logic [GW-1:0] size_wa, link_wa, mark_wa, link_wd;
  logic [SW-1:0] size_wd;

  logic [AW-1:0] wanted, g_end, it_end, lnk_byte;
  logic [15:0]   addr_off;
  logic [GW-1:0] fg, ng;
  logic [SW-1:0] rest;
  logic          merge_prev, out_free;

  // request decode
  assign wanted   = ((AW'(req.alloc_size) + AW'(HDR + ALIGN_BYTES - 1)) >> ALIGN_SH)
                    << ALIGN_SH;
  assign addr_off = req.free_address - 16'(HDR);
  assign fg       = GW'(addr_off >> ALIGN_SH);
  assign ng       = blk + GW'(wanted >> ALIGN_SH);
  assign rest     = sz_blk - SW'(wanted);
  assign g_end    = (AW'(g) << ALIGN_SH) + AW'(sz_g);
  assign it_end   = (AW'(it) << ALIGN_SH) + AW'(sz_it);
  assign lnk_byte = AW'(lnk) << ALIGN_SH;
  assign merge_prev = !it_none && (it_end == (AW'(g) << ALIGN_SH));
  assign out_free = !out_valid || !out_stall;

  assign st.clr_last = (clr == GW'(GRANULES - 1));
  assign st.is_alloc = (req.req_type == REQ_ALLOC);
  assign st.alloc_ok = (req.alloc_size != '0) && (wanted <= AW'(free_cnt));
  assign st.addr_ok  = (req.free_address >= 16'(HDR))
                       && (addr_off[ALIGN_SH-1:0] == '0) && (fg < END_GRAN);
  assign st.at_end   = (blk == END_GRAN);
  assign st.fits     = (AW'(rd_size) >= wanted);
  assign st.guard_ok = (guard <= GUARD_MAX);
  assign st.mark_set = rd_mark;
  assign st.do_split = (AW'(rest) > AW'(2 * HDR));
  assign st.pb_go    = (lnk < g) && (guard <= GUARD_MAX);
  assign st.nxt_adj  = (g_end == lnk_byte);
  assign st.nxt_end  = (lnk == END_GRAN);
  assign st.out_free = out_free;

  // memory port control
  always_comb begin
    rd_addr = blk;
    size_we = 1'b0; size_wa = blk; size_wd = '0;
    link_we = 1'b0; link_wa = blk; link_wd = '0;
    mark_we = 1'b0; mark_wa = blk; mark_wd = 1'b0;
    unique case (cmd.step)
      S_CLEAR: begin
        size_we = 1'b1; size_wa = clr; size_wd = (clr == '0) ? END_SIZE : '0;
        link_we = 1'b1; link_wa = clr; link_wd = (clr == '0) ? END_GRAN : '0;
        mark_we = 1'b1; mark_wa = clr;
      end
      S_DECODE:  rd_addr = fg;
      S_TAKE: begin
        if (!prev_none) begin
          link_we = 1'b1; link_wa = prv; link_wd = link_blk;
        end
        if (st.do_split) begin
          size_we = 1'b1; size_wa = ng; size_wd = rest;
        end
        mark_we = 1'b1; mark_wa = blk; mark_wd = 1'b1;
      end
      S_SPLIT: begin
        size_we = 1'b1; size_wa = blk; size_wd = SW'(wanted);
      end
      S_FREE_CHK: begin
        if (rd_mark) begin
          mark_we = 1'b1; mark_wa = g;
        end
      end
      S_PB_CHK:  rd_addr = lnk;
      S_PB_RDG:  rd_addr = g;
      S_PB_PREV: begin
        if (merge_prev) begin
          size_we = 1'b1; size_wa = it; size_wd = sz_it + rd_size;
        end
      end
      S_PB_NXCHK: begin
        rd_addr = lnk;
        if (st.nxt_adj && st.nxt_end) begin
          link_we = 1'b1; link_wa = g; link_wd = END_GRAN;
        end else if (!st.nxt_adj) begin
          link_we = 1'b1; link_wa = g; link_wd = lnk;
        end
      end
      S_PB_ABSRB: begin
        size_we = 1'b1; size_wa = g; size_wd = sz_g + rd_size;
        link_we = 1'b1; link_wa = g; link_wd = rd_link;
      end
      S_PB_LINK: begin
        if (!it_none && it != g) begin
          link_we = 1'b1; link_wa = it; link_wd = g;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (size_we) size_mem[size_wa] <= size_wd;
    if (link_we) link_mem[link_wa] <= link_wd;
    if (mark_we) mark_mem[mark_wa] <= mark_wd;
    rd_size <= size_mem[rd_addr];
    rd_link <= link_mem[rd_addr];
    rd_mark <= mark_mem[rd_addr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clr       <= '0;
      head      <= '0;
      free_cnt  <= END_SIZE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.step == S_CLEAR) clr <= clr + 1'b1;
      if (cmd.step == S_TAKE) begin
        if (prev_none) head <= link_blk;
        if (!st.do_split) free_cnt <= free_cnt - sz_blk;
      end
      if (cmd.step == S_SPLIT) free_cnt <= free_cnt - SW'(wanted);
      if (cmd.step == S_FREE_CHK && rd_mark) free_cnt <= free_cnt + rd_size;
      if (cmd.step == S_PB_LINK && it_none) head <= g;
      if (cmd.step == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // walk and payload registers
  always_ff @(posedge clk) begin
    if (cmd.step == S_IDLE && in_valid) req <= in_data;
    if (cmd.res_we) res_status <= cmd.res;
    unique case (cmd.step)
      S_DECODE: begin
        blk       <= head;
        prev_none <= 1'b1;
        guard     <= '0;
        g         <= fg;
        res_addr  <= '0;
      end
      S_WALK_EV: begin
        sz_blk   <= rd_size;
        link_blk <= rd_link;
        if (!st.fits && st.guard_ok) begin
          prv       <= blk;
          prev_none <= 1'b0;
          blk       <= rd_link;
          guard     <= guard + 1'b1;
        end
      end
      S_TAKE: begin
        res_addr <= 16'((AW'(blk) << ALIGN_SH) + AW'(HDR));
        g        <= ng;
      end
      S_PB_START: begin
        it_none <= 1'b1;
        guard   <= '0;
        lnk     <= head;
      end
      S_PB_CHK: begin
        if (st.pb_go) begin
          it      <= lnk;
          it_none <= 1'b0;
          guard   <= guard + 1'b1;
        end
      end
      S_PB_NEXT: begin
        lnk   <= rd_link;
        sz_it <= rd_size;
      end
      S_PB_PREV: begin
        if (merge_prev) begin
          g    <= it;
          sz_g <= sz_it + rd_size;
        end else begin
          sz_g <= rd_size;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_data.status        <= res_status;
          out_data.block_address <= res_addr;
          out_data.free_bytes    <= free_cnt;
          out_data.taken_bytes   <= HEAP_SIZE - free_cnt;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/first_fit_coalescing_allocator.sv =====
// ----------------------------------------------------------------------------
// first_fit_coalescing_allocator
// Address-ordered first-fit heap allocator with block split and coalescing.
// ----------------------------------------------------------------------------
// One request at a time. An allocation walks the free list block by block; when
// the block is split, the split tail is put back by a walk over the free blocks
// below it. A free walks the free blocks below the freed block. Either takes an
// extra absorb step on a merge with the right neighbor. A request rejected at
// decode skips the walk. The next transfer is taken in the cycle after the result
// is registered. After reset a clearing pass writes all 8192 header entries
// before the first request is taken.
module first_fit_coalescing_allocator (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  ffca_pkg::req_t in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output ffca_pkg::rsp_t out_data
);
  import ffca_pkg::*;

  cmd_t     cmd;
  dp_stat_t st;

  ffca_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .st       (st),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  ffca_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .st        (st)
  );

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// First-fit coalescing allocator testbench
// Drives allocate and free requests with random gaps and output stalls, keeps
// a shadow heap that tracks the free list, and checks every response field.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ffca_pkg::*;

  localparam int NO_LINK = -1;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  req_t in_data;
  logic out_valid;
  logic out_stall;
  rsp_t out_data;

  first_fit_coalescing_allocator DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // shadow heap
  int unsigned blk_size [GRANULES];
  int unsigned blk_next [GRANULES];
  bit          blk_taken[GRANULES];
  int unsigned head_gran;
  int unsigned bytes_free;

  rsp_t pending_rsp[$];
  int   errors;
  int   gap_max;
  int   stall_pct;
  logic [15:0] live_blocks[$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic int unsigned link_at(int it);
    if (it == NO_LINK) return head_gran;
    return blk_next[it % GRANULES];
  endfunction

  function automatic void link_set(int it, int unsigned v);
    if (it == NO_LINK) head_gran = v;
    else blk_next[it % GRANULES] = v;
  endfunction

  function automatic void heap_clear();
    foreach (blk_size[i]) begin
      blk_size[i] = 0;
      blk_next[i] = 0;
      blk_taken[i] = 0;
    end
    blk_size[0] = END_BYTE;
    blk_next[0] = END_G;
    head_gran = 0;
    bytes_free = END_BYTE;
  endfunction

  // insert granule g in address order and merge with neighbors
  function automatic void list_insert(int unsigned g_in);
    int it;
    int unsigned g, nxt, guard;
    it = NO_LINK;
    g = g_in;
    guard = 0;
    while (link_at(it) < g && guard <= GRANULES) begin
      it = link_at(it) % GRANULES;
      guard++;
    end
    if (it != NO_LINK && it * ALIGN_BYTES + blk_size[it] == g * ALIGN_BYTES) begin
      blk_size[it] += blk_size[g];
      g = it;
    end
    nxt = link_at(it) % GRANULES;
    if (g * ALIGN_BYTES + blk_size[g] == nxt * ALIGN_BYTES) begin
      if (nxt != END_G) begin
        blk_size[g] += blk_size[nxt];
        blk_next[g] = blk_next[nxt];
      end else begin
        blk_next[g] = END_G;
      end
    end else begin
      blk_next[g] = nxt;
    end
    if (it != int'(g)) link_set(it, g);
  endfunction

  function automatic rsp_t heap_request(req_t r);
    rsp_t o;
    int unsigned sz, wanted, blk, guard, a, g, ng;
    int prev;
    o = '0;
    o.status = ST_IGNORED;
    if (r.req_type == REQ_ALLOC) begin
      sz = r.alloc_size;
      wanted = (sz + HDR + ALIGN_BYTES - 1) & ~(ALIGN_BYTES - 1);
      o.status = ST_NULL;
      if (sz != 0 && wanted <= bytes_free) begin
        prev = NO_LINK;
        blk = head_gran % GRANULES;
        guard = 0;
        while (blk != END_G && blk_size[blk] < wanted && guard <= GRANULES) begin
          prev = blk;
          blk = blk_next[blk] % GRANULES;
          guard++;
        end
        if (blk != END_G && blk_size[blk] >= wanted) begin
          o.block_address = 16'(blk * ALIGN_BYTES + HDR);
          link_set(prev, blk_next[blk]);
          if (blk_size[blk] - wanted > 2 * HDR) begin
            ng = (blk + wanted / ALIGN_BYTES) % GRANULES;
            blk_size[ng] = blk_size[blk] - wanted;
            blk_size[blk] = wanted;
            list_insert(ng);
          end
          bytes_free -= blk_size[blk];
          blk_taken[blk] = 1;
          o.status = ST_DONE;
        end
      end
    end else begin
      a = r.free_address;
      if (a >= HDR && ((a - HDR) % ALIGN_BYTES) == 0) begin
        g = (a - HDR) / ALIGN_BYTES;
        if (g < END_G && blk_taken[g]) begin
          blk_taken[g] = 0;
          bytes_free += blk_size[g];
          list_insert(g);
          o.status = ST_DONE;
        end
      end
    end
    o.free_bytes = 17'(bytes_free);
    o.taken_bytes = 17'(HEAP_BYTES - bytes_free);
    return o;
  endfunction

  // one transfer; prediction made at acceptance, valid dropped by the next idle
  task automatic send_req(logic typ, logic [16:0] sz, logic [15:0] addr);
    req_t r;
    rsp_t e;
    int gap;
    gap = (gap_max > 0 && $urandom_range(0, 3) == 0) ? $urandom_range(0, gap_max) : 0;
    r.req_type = typ;
    r.alloc_size = sz;
    r.free_address = addr;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data <= r;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    e = heap_request(r);
    pending_rsp.push_back(e);
    if (typ == REQ_ALLOC && e.status == ST_DONE) live_blocks.push_back(e.block_address);
  endtask

  task automatic do_alloc(logic [16:0] sz);
    send_req(REQ_ALLOC, sz, '0);
  endtask

  task automatic do_free(logic [15:0] addr);
    send_req(REQ_FREE, '0, addr);
  endtask

  task automatic free_live_random();
    int k;
    logic [15:0] a;
    k = $urandom_range(0, live_blocks.size() - 1);
    a = live_blocks[k];
    live_blocks.delete(k);
    do_free(a);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(negedge clk);
  endtask

  // response checker
  always @(posedge clk) begin
    rsp_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_rsp.size() == 0) begin
        $display("%0t: unexpected response %p", $time, out_data);
        errors++;
      end else begin
        e = pending_rsp.pop_front();
        if (out_data.status !== e.status) begin
          $display("%0t: status expected %0d actual %0d", $time, e.status, out_data.status);
          errors++;
        end
        if (out_data.block_address !== e.block_address) begin
          $display("%0t: block_address expected %0d actual %0d", $time,
                   e.block_address, out_data.block_address);
          errors++;
        end
        if (out_data.free_bytes !== e.free_bytes) begin
          $display("%0t: free_bytes expected %0d actual %0d", $time,
                   e.free_bytes, out_data.free_bytes);
          errors++;
        end
        if (out_data.taken_bytes !== e.taken_bytes) begin
          $display("%0t: taken_bytes expected %0d actual %0d", $time,
                   e.taken_bytes, out_data.taken_bytes);
          errors++;
        end
      end
    end
  end

  // receiver stall pattern
  always @(negedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  task automatic test_edges();
    do_alloc(17'd0);
    do_alloc(17'h1FFFF);
    do_alloc(17'd65536);
    do_free(16'd0);
    do_free(16'd8);
    do_free(16'd17);
    do_free(16'hFFFF);
    do_free(16'(END_BYTE + HDR));
    do_free(16'd16);           // not yet allocated
    do_alloc(17'(END_BYTE - HDR)); // whole heap
    do_alloc(17'd1);
    do_free(16'd16);
    do_free(16'd16);           // double free
  endtask

  task automatic test_coalesce();
    do_alloc(17'd1);
    do_alloc(17'd100);
    do_alloc(17'd40);
    do_alloc(17'd8);
    do_free(16'd16);
    do_free(16'd56 + 16'd16);  // not a block start: ignored
    do_alloc(17'd20);
    do_alloc(17'd7);
    while (live_blocks.size() != 0) free_live_random();
    do_alloc(17'(END_BYTE - HDR));
    do_alloc(17'(END_BYTE - HDR - 7));
    while (live_blocks.size() != 0) free_live_random();
  endtask

  task automatic test_random(int n);
    int i, burst;
    logic [16:0] sz;
    i = 0;
    while (i < n) begin
      burst = $urandom_range(1, 20);
      repeat (burst) begin
        case ($urandom_range(0, 9)) inside
          [0:3]: begin
            sz = ($urandom_range(0, 15) == 0) ? 17'($urandom) : 17'($urandom_range(1, 300));
            do_alloc(sz);
          end
          4: do_alloc(17'($urandom_range(1, 8000)));
          [5:7]: begin
            if (live_blocks.size() != 0) free_live_random();
            else do_alloc(17'($urandom_range(1, 64)));
          end
          8: do_free(16'($urandom));
          default: begin
            if (live_blocks.size() != 0)
              do_free(live_blocks[$urandom_range(0, live_blocks.size() - 1)]);
            else do_free(16'($urandom_range(0, 64)));
          end
        endcase
        i++;
      end
      if ($urandom_range(0, 3) == 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 30)) @(negedge clk);
      end
    end
  endtask

  initial begin
    errors = 0;
    gap_max = 0;
    stall_pct = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    heap_clear();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_edges();
    test_coalesce();
    drain();
    gap_max = 4;
    stall_pct = 30;
    test_random(600);
    drain();                   // sender holds off until all responses are in
    stall_pct = 0;
    gap_max = 0;
    test_random(300);
    stall_pct = 60;
    gap_max = 8;
    test_random(300);
    drain();
    repeat (100) @(negedge clk);
    if (errors == 0 && pending_rsp.size() == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
